// ----- rtl/quaternion_to_rotation_matrix_top_defines.svh -----
// Assertion macros used by the top-level RTL.
`ifndef QUATERNION_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_TOP_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define QRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form.
`define QRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qrm_pkg.sv -----
`timescale 1ns / 1ps
package qrm_pkg;
  localparam int FracBits = 30;
  localparam int QBits    = FracBits + 2;   // quotient bits: integer bit, fraction, round bit
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int PairW    = ProdW + 1;
  localparam int SumW     = ProdW + 3;      // numerators, sum of squares, remainders
  localparam int NumProd  = 10;
  localparam int NumPair  = 12;
  localparam int NumLanes = 9;

  // product order
  localparam int PWW = 0, PXX = 1, PYY = 2, PZZ = 3, PXY = 4;
  localparam int PXZ = 5, PYZ = 6, PWX = 7, PWY = 8, PWZ = 9;

  typedef struct packed {
    logic [NumProd-1:0][ProdW-1:0] p;
  } prod_t;

  typedef struct packed {
    logic [SumW-1:0]                 s;
    logic [NumLanes-1:0][SumW-1:0]   r;
    logic [NumLanes-1:0][QBits-1:0]  q;
    logic [NumLanes-1:0]             neg;
    logic                            deg;
  } div_t;
endpackage

// ----- rtl/qrm_mult.sv -----
`timescale 1ns / 1ps
// Stage 1: the ten quaternion products, one multiplier each.
module qrm_mult (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qrm_pkg::DataW-1:0]     w_i,
  input  logic [qrm_pkg::DataW-1:0]     x_i,
  input  logic [qrm_pkg::DataW-1:0]     y_i,
  input  logic [qrm_pkg::DataW-1:0]     z_i,
  output logic                          valid_o,
  output qrm_pkg::prod_t                prod_o
);
  logic           valid_q;
  qrm_pkg::prod_t prod_d, prod_q;

  always_comb begin
    prod_d.p[qrm_pkg::PWW] = $signed(w_i) * $signed(w_i);
    prod_d.p[qrm_pkg::PXX] = $signed(x_i) * $signed(x_i);
    prod_d.p[qrm_pkg::PYY] = $signed(y_i) * $signed(y_i);
    prod_d.p[qrm_pkg::PZZ] = $signed(z_i) * $signed(z_i);
    prod_d.p[qrm_pkg::PXY] = $signed(x_i) * $signed(y_i);
    prod_d.p[qrm_pkg::PXZ] = $signed(x_i) * $signed(z_i);
    prod_d.p[qrm_pkg::PYZ] = $signed(y_i) * $signed(z_i);
    prod_d.p[qrm_pkg::PWX] = $signed(w_i) * $signed(x_i);
    prod_d.p[qrm_pkg::PWY] = $signed(w_i) * $signed(y_i);
    prod_d.p[qrm_pkg::PWZ] = $signed(w_i) * $signed(z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
endmodule

// ----- rtl/qrm_sum.sv -----
`timescale 1ns / 1ps
// Stages 2-4: pair sums, numerators and sum of squares, then magnitude/sign.
module qrm_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qrm_pkg::prod_t  prod_i,
  output logic            valid_o,
  output qrm_pkg::div_t   div_o
);
  localparam int PairW = qrm_pkg::PairW;
  localparam int SumW  = qrm_pkg::SumW;

  logic [2:0] valid_q;
  logic [qrm_pkg::NumPair-1:0][PairW-1:0]        pr_d, pr_q;
  logic [qrm_pkg::NumLanes-1:0][SumW-1:0]        n_d, n_q;
  logic [SumW-1:0]                               s_d, s_q;
  qrm_pkg::div_t                                 div_d, div_q;

  function automatic logic [PairW-1:0] pw(input logic [qrm_pkg::ProdW-1:0] a);
    pw = {a[qrm_pkg::ProdW-1], a};
  endfunction

  function automatic logic [SumW-1:0] sx(input logic [PairW-1:0] a);
    sx = {{(SumW-PairW){a[PairW-1]}}, a};
  endfunction

  always_comb begin
    pr_d[0]  = pw(prod_i.p[qrm_pkg::PWW]) + pw(prod_i.p[qrm_pkg::PXX]);
    pr_d[1]  = pw(prod_i.p[qrm_pkg::PYY]) + pw(prod_i.p[qrm_pkg::PZZ]);
    pr_d[2]  = pw(prod_i.p[qrm_pkg::PWW]) + pw(prod_i.p[qrm_pkg::PYY]);
    pr_d[3]  = pw(prod_i.p[qrm_pkg::PXX]) + pw(prod_i.p[qrm_pkg::PZZ]);
    pr_d[4]  = pw(prod_i.p[qrm_pkg::PWW]) + pw(prod_i.p[qrm_pkg::PZZ]);
    pr_d[5]  = pw(prod_i.p[qrm_pkg::PXX]) + pw(prod_i.p[qrm_pkg::PYY]);
    pr_d[6]  = pw(prod_i.p[qrm_pkg::PXY]) + pw(prod_i.p[qrm_pkg::PWZ]);
    pr_d[7]  = pw(prod_i.p[qrm_pkg::PXY]) - pw(prod_i.p[qrm_pkg::PWZ]);
    pr_d[8]  = pw(prod_i.p[qrm_pkg::PXZ]) - pw(prod_i.p[qrm_pkg::PWY]);
    pr_d[9]  = pw(prod_i.p[qrm_pkg::PXZ]) + pw(prod_i.p[qrm_pkg::PWY]);
    pr_d[10] = pw(prod_i.p[qrm_pkg::PYZ]) + pw(prod_i.p[qrm_pkg::PWX]);
    pr_d[11] = pw(prod_i.p[qrm_pkg::PYZ]) - pw(prod_i.p[qrm_pkg::PWX]);
  end

  always_comb begin
    s_d    = sx(pr_q[0]) + sx(pr_q[1]);
    n_d[0] = sx(pr_q[0]) - sx(pr_q[1]);
    n_d[1] = sx(pr_q[6]) << 1;
    n_d[2] = sx(pr_q[8]) << 1;
    n_d[3] = sx(pr_q[7]) << 1;
    n_d[4] = sx(pr_q[2]) - sx(pr_q[3]);
    n_d[5] = sx(pr_q[10]) << 1;
    n_d[6] = sx(pr_q[9]) << 1;
    n_d[7] = sx(pr_q[11]) << 1;
    n_d[8] = sx(pr_q[4]) - sx(pr_q[5]);
  end

  always_comb begin
    div_d.s   = s_q;
    div_d.deg = (s_q == '0);
    for (int k = 0; k < qrm_pkg::NumLanes; k++) begin
      div_d.neg[k] = n_q[k][SumW-1];
      div_d.r[k]   = n_q[k][SumW-1] ? (SumW)'(-n_q[k]) : n_q[k];
      div_d.q[k]   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q  <= pr_d;
      n_q   <= n_d;
      s_q   <= s_d;
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q[2];
  assign div_o   = div_q;
endmodule

// ----- rtl/qrm_div_step.sv -----
`timescale 1ns / 1ps
// One restoring-division step for all nine lanes; remainder leaves pre-shifted.
module qrm_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qrm_pkg::div_t  div_i,
  output logic           valid_o,
  output qrm_pkg::div_t  div_o
);
  localparam int SumW  = qrm_pkg::SumW;
  localparam int QBits = qrm_pkg::QBits;

  logic          valid_q;
  qrm_pkg::div_t div_d, div_q;

  always_comb begin
    div_d = div_i;
    for (int k = 0; k < qrm_pkg::NumLanes; k++) begin
      if (div_i.r[k] >= div_i.s) begin
        div_d.r[k] = (div_i.r[k] - div_i.s) << 1;
        div_d.q[k] = {div_i.q[k][QBits-2:0], 1'b1};
      end else begin
        div_d.r[k] = div_i.r[k] << 1;
        div_d.q[k] = {div_i.q[k][QBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
endmodule

// ----- rtl/qrm_round.sv -----
`timescale 1ns / 1ps
// Final stage: round half away from zero, restore sign, zero on degenerate.
module qrm_round (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            valid_i,
  input  qrm_pkg::div_t                                   div_i,
  output logic                                            valid_o,
  output logic [qrm_pkg::NumLanes-1:0][qrm_pkg::DataW-1:0] m_o,
  output logic                                            deg_o
);
  localparam int QBits = qrm_pkg::QBits;
  localparam int DataW = qrm_pkg::DataW;

  logic                                     valid_q;
  logic [qrm_pkg::NumLanes-1:0][DataW-1:0]  m_d, m_q;
  logic                                     deg_q;
  logic [QBits-1:0]                         mag;

  always_comb begin
    mag = '0;
    for (int k = 0; k < qrm_pkg::NumLanes; k++) begin
      mag    = (div_i.q[k] >> 1) + QBits'(div_i.q[k][0]);
      m_d[k] = div_i.deg ? '0 : (div_i.neg[k] ? DataW'(-mag) : DataW'(mag));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= m_d;
      deg_q <= div_i.deg;
    end
  end

  assign valid_o = valid_q;
  assign m_o     = m_q;
  assign deg_o   = deg_q;
endmodule

// ----- rtl/quaternion_to_rotation_matrix_top.sv -----
// Quaternion to 3x3 rotation matrix. One quaternion (w,x,y,z, signed Q2.30)
// per transaction in, nine matrix entries (signed Q2.30) per transaction out.
// Each entry is its quadratic form divided by S = w^2+x^2+y^2+z^2, so any
// non-zero scale gives the same matrix; entries are rounded to nearest with
// ties away from zero and lie in [-1.0, +1.0]. An all-zero quaternion gives
// a zero matrix with the degenerate flag (tuser) set. Fully pipelined: one
// transaction per clock sustained while m_axis_tready holds; 1 multiply
// stage, 3 add/normalize stages, 32 restoring-division stages, 1 rounding
// stage (the division chain sets the depth). The whole pipe advances together
// whenever the output register is empty or being taken, so s_axis_tready
// follows m_axis_tready combinationally. No state between transactions.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_top_defines.svh"
module quaternion_to_rotation_matrix_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // q_w[31:0], q_x, q_y, q_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // m00[31:0], m01, m02, m10, m11, m12, m20, m21, m22
  output logic [0:0]   m_axis_tuser    // degenerate
);
  localparam int DataW = qrm_pkg::DataW;
  localparam int QBits = qrm_pkg::QBits;

  logic           en;
  logic           mult_vld;
  qrm_pkg::prod_t prod;
  logic           sum_vld;

  // division chain: index 0 is the chain input, QBits its output
  logic          div_vld [QBits+1];
  qrm_pkg::div_t div     [QBits+1];

  logic [qrm_pkg::NumLanes-1:0][DataW-1:0] m;
  logic                                   deg;
  logic                                   out_vld;

  // global advance: empty output slot or it is being drained this cycle
  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  qrm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .w_i     (s_axis_tdata[DataW-1:0]),
    .x_i     (s_axis_tdata[2*DataW-1:DataW]),
    .y_i     (s_axis_tdata[3*DataW-1:2*DataW]),
    .z_i     (s_axis_tdata[4*DataW-1:3*DataW]),
    .valid_o (mult_vld),
    .prod_o  (prod)
  );

  qrm_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mult_vld),
    .prod_i  (prod),
    .valid_o (sum_vld),
    .div_o   (div[0])
  );
  assign div_vld[0] = sum_vld;

  // one quotient bit per stage: integer bit, fraction bits, round bit
  for (genvar g = 0; g < QBits; g++) begin : g_div
    qrm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_vld[g]),
      .div_i   (div[g]),
      .valid_o (div_vld[g+1]),
      .div_o   (div[g+1])
    );
  end

  qrm_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld[QBits]),
    .div_i   (div[QBits]),
    .valid_o (out_vld),
    .m_o     (m),
    .deg_o   (deg)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = m;
  assign m_axis_tuser  = deg;

  // a degenerate result carries an all-zero matrix
  `QRM_ASSERT_IMP(a_deg_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "degenerate result with non-zero matrix")
  // a stalled result is never dropped by the pipe advance
  `QRM_ASSERT_IMP(a_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "stalled result lost")
  // input taken while a result waits only when that result leaves too
  `QRM_ASSERT_IMP(a_no_overrun, s_axis_tready && m_axis_tvalid, m_axis_tready, "pipe advanced over a waiting result")
  // diagonal entry stays within unit magnitude
  `QRM_ASSERT_IMP(a_m00_range, m_axis_tvalid, ($signed(m_axis_tdata[31:0]) <= 32'sd1073741824) && ($signed(m_axis_tdata[31:0]) >= -32'sd1073741824), "m00 out of range")
endmodule
